[src/hlpr_pkg.sv]
// Package for the HLP container reassembler: parser phase codes, element ids,
// the LLC/SNAP header constant and the result record type.
// No dependencies.
package hlpr_pkg;

    localparam int MAX_PACKET_BYTES_DEF = 4095;

    // Results one input byte can cause: six released header bytes plus an end marker
    localparam int MAX_RESULTS = 8;
    localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] EID_EXT      = 8'd255;
    localparam logic [7:0] EID_FRAG     = 8'd242;
    localparam logic [7:0] EXT_HLP      = 8'd5;
    localparam logic [7:0] MIN_CONT_LEN = 8'd13;

    // Header byte i sits at bits [47-8i -: 8]
    localparam logic [47:0] SNAP_HEADER = 48'haaaa_0300_0000;

    localparam logic [3:0] MAC_BYTES   = 4'd6;
    localparam logic [3:0] MACS_BYTES  = 4'd12;
    localparam logic [2:0] HOLD_BYTES  = 3'd6;
    localparam logic [2:0] HOLD_STRIP  = 3'd6;
    localparam logic [2:0] HOLD_PASS   = 3'd7;

    typedef enum logic [5:0] {
        PH_ID   = 6'b000001,
        PH_LEN  = 6'b000010,
        PH_SKIP = 6'b000100,
        PH_EXT  = 6'b001000,
        PH_BODY = 6'b010000,
        PH_STOP = 6'b100000
    } t_phase;

    typedef enum logic [3:0] {
        HP_SCAN   = 4'b0001,
        HP_OPEN   = 4'b0010,
        HP_FOLLOW = 4'b0100,
        HP_CONT   = 4'b1000
    } t_hpos;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic [11:0] kept;
        logic        pkt_valid;
    } t_result;

endpackage

[src/hlpr_parser.sv]
// Element parser of the HLP container reassembler: parse state and the
// result list caused by one byte. Depends on hlpr_pkg.
module hlpr_parser #(
    parameter int MAX_PACKET_BYTES = hlpr_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_go,
    input  logic [7:0]                     i_byte,
    input  logic                           i_last,
    input  logic [47:0]                    i_station,
    output hlpr_pkg::t_result              o_res [hlpr_pkg::MAX_RESULTS],
    output logic [hlpr_pkg::RES_CNT_W-1:0] o_res_cnt
);

    localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PACKET_BYTES);
    localparam logic [CNT_W-1:0] CNT_SIX = CNT_W'(6);

    hlpr_pkg::t_phase r_phase, n_phase;
    hlpr_pkg::t_hpos  r_hpos, n_hpos;
    logic [7:0]       r_kind, n_kind;
    logic [7:0]       r_rem, n_rem;
    logic [3:0]       r_mac, n_mac;
    logic             r_sm, n_sm;
    logic [7:0]       r_hold [6];
    logic [7:0]       n_hold [6];
    logic [2:0]       r_hc, n_hc;
    logic [CNT_W-1:0] r_emit, n_emit;
    logic [CNT_W-1:0] r_cl, n_cl;

    always_comb begin
        logic [hlpr_pkg::RES_CNT_W-1:0] k;
        logic [7:0]       rem_dec;
        logic [2:0]       j;
        logic             same;
        logic             do_close;
        logic             close_ok;
        logic [CNT_W-1:0] kf;

        n_phase = r_phase;
        n_hpos  = r_hpos;
        n_kind  = r_kind;
        n_rem   = r_rem;
        n_mac   = r_mac;
        n_sm    = r_sm;
        n_hc    = r_hc;
        n_emit  = r_emit;
        n_cl    = r_cl;
        for (int i = 0; i < 6; i++) begin
            n_hold[i] = r_hold[i];
        end
        for (int i = 0; i < hlpr_pkg::MAX_RESULTS; i++) begin
            o_res[i] = '0;
        end
        k        = '0;
        rem_dec  = (r_rem != 8'd0) ? r_rem - 8'd1 : 8'd0;
        j        = 3'(r_mac - hlpr_pkg::MAC_BYTES);
        same     = 1'b0;
        do_close = 1'b0;
        close_ok = 1'b1;
        kf       = '0;

        unique case (r_phase)
            hlpr_pkg::PH_ID: begin
                n_kind  = i_byte;
                n_phase = hlpr_pkg::PH_LEN;
                if (r_hpos == hlpr_pkg::HP_OPEN && i_byte != hlpr_pkg::EID_FRAG) begin
                    do_close = 1'b1;
                    n_hpos   = hlpr_pkg::HP_FOLLOW;
                end
            end
            hlpr_pkg::PH_LEN: begin
                n_rem = i_byte;
                priority if (r_hpos == hlpr_pkg::HP_OPEN) begin
                    n_phase = (i_byte == 8'd0) ? hlpr_pkg::PH_ID : hlpr_pkg::PH_BODY;
                end else if (r_kind == hlpr_pkg::EID_EXT
                             && i_byte >= hlpr_pkg::MIN_CONT_LEN) begin
                    n_phase = hlpr_pkg::PH_EXT;
                end else if (r_hpos == hlpr_pkg::HP_SCAN) begin
                    n_phase = (i_byte == 8'd0) ? hlpr_pkg::PH_ID : hlpr_pkg::PH_SKIP;
                end else begin
                    n_phase = hlpr_pkg::PH_STOP;
                end
            end
            hlpr_pkg::PH_SKIP: begin
                n_rem = rem_dec;
                if (rem_dec == 8'd0) begin
                    n_phase = hlpr_pkg::PH_ID;
                end
            end
            hlpr_pkg::PH_EXT: begin
                n_rem = rem_dec;
                priority if (i_byte == hlpr_pkg::EXT_HLP) begin
                    n_hpos  = hlpr_pkg::HP_CONT;
                    n_mac   = '0;
                    n_sm    = 1'b1;
                    n_hc    = '0;
                    n_emit  = '0;
                    n_cl    = '0;
                    n_phase = hlpr_pkg::PH_BODY;
                    for (int i = 0; i < 6; i++) begin
                        n_hold[i] = '0;
                    end
                end else if (r_hpos == hlpr_pkg::HP_SCAN) begin
                    n_phase = hlpr_pkg::PH_SKIP;
                end else begin
                    n_phase = hlpr_pkg::PH_STOP;
                end
            end
            hlpr_pkg::PH_BODY: begin
                if (r_mac < hlpr_pkg::MACS_BYTES) begin
                    // Second MAC is the source: check it against the station
                    if (r_mac >= hlpr_pkg::MAC_BYTES
                        && i_station[(3'd5 - j) * 8 +: 8] != i_byte) begin
                        n_sm = 1'b0;
                    end
                    n_mac = r_mac + 4'd1;
                end else begin
                    if (r_hc < hlpr_pkg::HOLD_BYTES) begin
                        n_hold[r_hc] = i_byte;
                        n_hc         = r_hc + 3'd1;
                        if (r_hc == hlpr_pkg::HOLD_BYTES - 3'd1) begin
                            same = 1'b1;
                            for (int i = 0; i < 6; i++) begin
                                if (n_hold[i] != hlpr_pkg::SNAP_HEADER[(5 - i) * 8 +: 8]) begin
                                    same = 1'b0;
                                end
                            end
                            // Not a SNAP header: release the held bytes if the source matched
                            if (!same) begin
                                n_hc = hlpr_pkg::HOLD_PASS;
                                if (r_sm) begin
                                    for (int i = 0; i < 6; i++) begin
                                        o_res[k[hlpr_pkg::RES_IDX_W-1:0]].kind =
                                            hlpr_pkg::KIND_PAYLOAD;
                                        o_res[k[hlpr_pkg::RES_IDX_W-1:0]].data = n_hold[i];
                                        k = k + 1'b1;
                                    end
                                end
                            end
                        end
                    end else if (r_sm) begin
                        o_res[k[hlpr_pkg::RES_IDX_W-1:0]].kind = hlpr_pkg::KIND_PAYLOAD;
                        o_res[k[hlpr_pkg::RES_IDX_W-1:0]].data = i_byte;
                        k = k + 1'b1;
                    end
                    if (r_emit < CNT_MAX) begin
                        n_emit = r_emit + 1'b1;
                    end
                end
                n_rem = rem_dec;
                if (rem_dec == 8'd0) begin
                    n_cl    = n_emit;
                    n_phase = hlpr_pkg::PH_ID;
                    if (r_hpos == hlpr_pkg::HP_CONT) begin
                        n_hpos = hlpr_pkg::HP_OPEN;
                    end
                end
            end
            hlpr_pkg::PH_STOP: begin
            end
            default: begin
            end
        endcase

        if (i_last) begin
            if (n_hpos == hlpr_pkg::HP_OPEN) begin
                do_close = 1'b1;
            end else if (n_hpos == hlpr_pkg::HP_CONT) begin
                do_close = 1'b1;
                close_ok = 1'b0;
            end
        end

        // Close an open packet: flush a partial header, then the end marker
        if (do_close && n_sm) begin
            if (close_ok && n_hc < hlpr_pkg::HOLD_BYTES) begin
                for (int i = 0; i < 5; i++) begin
                    if (3'(i) < n_hc) begin
                        o_res[k[hlpr_pkg::RES_IDX_W-1:0]].kind = hlpr_pkg::KIND_PAYLOAD;
                        o_res[k[hlpr_pkg::RES_IDX_W-1:0]].data = n_hold[i];
                        k = k + 1'b1;
                    end
                end
            end
            if (n_hc == hlpr_pkg::HOLD_STRIP) begin
                kf = (n_cl >= CNT_SIX) ? n_cl - CNT_SIX : '0;
            end else begin
                kf = n_cl;
            end
            o_res[k[hlpr_pkg::RES_IDX_W-1:0]].kind      = hlpr_pkg::KIND_END;
            o_res[k[hlpr_pkg::RES_IDX_W-1:0]].pkt_valid = close_ok;
            if (close_ok) begin
                o_res[k[hlpr_pkg::RES_IDX_W-1:0]].kept =
                    (32'(kf) > 32'd4095) ? 12'hFFF : 12'(kf);
            end
            k = k + 1'b1;
        end

        // End of buffer: back to scanning
        if (i_last) begin
            n_phase = hlpr_pkg::PH_ID;
            n_hpos  = hlpr_pkg::HP_SCAN;
            n_kind  = '0;
            n_rem   = '0;
            n_mac   = '0;
            n_sm    = 1'b1;
            n_hc    = '0;
            n_emit  = '0;
            n_cl    = '0;
            for (int i = 0; i < 6; i++) begin
                n_hold[i] = '0;
            end
        end

        o_res_cnt = k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hlpr_pkg::PH_ID;
            r_hpos  <= hlpr_pkg::HP_SCAN;
            r_kind  <= '0;
            r_rem   <= '0;
            r_mac   <= '0;
            r_sm    <= 1'b1;
            r_hc    <= '0;
            r_emit  <= '0;
            r_cl    <= '0;
        end else if (i_go) begin
            r_phase <= n_phase;
            r_hpos  <= n_hpos;
            r_kind  <= n_kind;
            r_rem   <= n_rem;
            r_mac   <= n_mac;
            r_sm    <= n_sm;
            r_hc    <= n_hc;
            r_emit  <= n_emit;
            r_cl    <= n_cl;
        end
    end

    // Held bytes are read only below the hold count, so they need no reset
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            for (int i = 0; i < 6; i++) begin
                r_hold[i] <= n_hold[i];
            end
        end
    end

endmodule

[src/hlpr_out_queue.sv]
// Result buffer of the HLP container reassembler: holds the results of one
// byte and hands them out one per transaction. Depends on hlpr_pkg.
module hlpr_out_queue (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  hlpr_pkg::t_result              i_res [hlpr_pkg::MAX_RESULTS],
    input  logic [hlpr_pkg::RES_CNT_W-1:0] i_res_cnt,
    output logic                           o_free,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_result_kind,
    output logic [7:0]                     o_payload_byte,
    output logic [11:0]                    o_kept_length,
    output logic                           o_packet_valid
);

    hlpr_pkg::t_result              r_buf [hlpr_pkg::MAX_RESULTS];
    logic [hlpr_pkg::RES_CNT_W-1:0] r_cnt;
    logic [hlpr_pkg::RES_IDX_W-1:0] r_rd;
    logic                           take;
    hlpr_pkg::t_result              head;

    assign o_out_valid = (r_cnt != '0);
    assign take        = o_out_valid && !i_out_stall;
    // Accept a new list once the last waiting result leaves
    assign o_free      = (r_cnt == '0) || (r_cnt == hlpr_pkg::RES_CNT_W'(1) && take);

    assign head           = r_buf[r_rd];
    assign o_result_kind  = head.kind;
    assign o_payload_byte = head.data;
    assign o_kept_length  = head.kept;
    assign o_packet_valid = head.pkt_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= '0;
        end else if (i_load) begin
            r_cnt <= i_res_cnt;
            r_rd  <= '0;
        end else if (take) begin
            r_cnt <= r_cnt - 1'b1;
            r_rd  <= r_rd + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int i = 0; i < hlpr_pkg::MAX_RESULTS; i++) begin
                r_buf[i] <= i_res[i];
            end
        end
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("result list loaded over waiting results");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_rd) + 32'(r_cnt)) <= hlpr_pkg::MAX_RESULTS)
        else $error("result read pointer ran past the buffer");

    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == hlpr_pkg::KIND_PAYLOAD)
            |-> (o_kept_length == 12'd0 && !o_packet_valid))
        else $error("payload result carries end marker fields");

    a_drain_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !i_load) |=> (r_cnt == $past(r_cnt) - 1'b1))
        else $error("result count did not follow a taken transaction");

endmodule

[src/hlp_container_reassembler.sv]
// HLP container reassembler, top level: input register, station address
// register, element parser and result buffer. Depends on hlpr_pkg,
// hlpr_parser and hlpr_out_queue.
//
// Feed the information-element buffer one byte per transaction, with
// i_last_byte on its final byte. A byte is taken every cycle as long as
// each byte causes at most one result and the output is not stalled; a byte
// that causes several results (up to seven: a released six-byte header plus an
// end marker) occupies the result buffer until all but its last result have
// left, and the input stalls meanwhile, since results leave through one output
// port from an eight-entry result buffer. o_out_valid rises once a byte with
// results has passed the input register and been loaded into the result
// buffer. Results are payload bytes followed by an end marker carrying the
// kept length and a packet-valid flag. Write i_cfg_wr_data to set the station
// address (first octet in bits 47..40) only while idle.
module hlp_container_reassembler #(
    parameter int MAX_PACKET_BYTES = hlpr_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [47:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_ie_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_result_kind,
    output logic [7:0]  o_payload_byte,
    output logic [11:0] o_kept_length,
    output logic        o_packet_valid
);

    logic [47:0] r_station;
    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        free;
    logic        go;
    logic        in_take;

    hlpr_pkg::t_result              res [hlpr_pkg::MAX_RESULTS];
    logic [hlpr_pkg::RES_CNT_W-1:0] res_cnt;

    assign go         = r_in_vld && free;
    assign o_in_stall = r_in_vld && !go;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station <= '0;
        end else if (i_cfg_wr_en) begin
            r_station <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (go) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_ie_byte;
            r_in_last <= i_last_byte;
        end
    end

    hlpr_parser #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (go),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .i_station (r_station),
        .o_res     (res),
        .o_res_cnt (res_cnt)
    );

    hlpr_out_queue u_out_queue (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (go),
        .i_res          (res),
        .i_res_cnt      (res_cnt),
        .o_free         (free),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_kind  (o_result_kind),
        .o_payload_byte (o_payload_byte),
        .o_kept_length  (o_kept_length),
        .o_packet_valid (o_packet_valid)
    );

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_vld && !free))
        else $error("input stalled with room to advance");

    a_go_consumes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && !in_take) |=> !r_in_vld)
        else $error("input register kept a processed byte");

    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_in_vld)
        else $error("accepted byte not held in input register");

endmodule
